// ----- rtl/sdeq_pkg.sv -----
// types and constants shared by the sorted double-ended queue
`timescale 1ns / 1ps

package sdeq_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W = 16;
  localparam int COUNT_W = 7;
  // entries folded into one register of the first read stage
  localparam int GATHER_W = 32;

  typedef enum logic [1:0] {
    MODE_INSERT       = 2'd0,
    MODE_DEL_LARGEST  = 2'd1,
    MODE_DEL_SMALLEST = 2'd2,
    MODE_READ         = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    CS_IDLE   = 1'b0,
    CS_GATHER = 1'b1
  } ctl_state_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] item;
    logic [COUNT_W-1:0]        count;
  } rsp_t;

  typedef struct packed {
    logic                      ins;
    logic                      del_front;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

// ----- rtl/sdeq_cell.sv -----
// one slot of the sorted chain: compare against the new value and shift
`timescale 1ns / 1ps

module sdeq_cell (
  input  logic                               clk,
  input  sdeq_pkg::cell_ctl_t                ctl,
  input  logic                               valid,
  input  logic                               prev_less,
  input  logic signed [sdeq_pkg::VALUE_W-1:0] left_entry,
  input  logic signed [sdeq_pkg::VALUE_W-1:0] right_entry,
  output logic                               less,
  output logic signed [sdeq_pkg::VALUE_W-1:0] entry
);

  // held entry strictly below the incoming value
  assign less = valid && (entry < ctl.value);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!less) begin
        entry <= prev_less ? ctl.value : left_entry;
      end
    end else if (ctl.del_front) begin
      entry <= right_entry;
    end
  end

endmodule

// ----- rtl/sorted_double_ended_queue_top.sv -----
// top level of the sorted double-ended queue: cell chain, count and read gather
`timescale 1ns / 1ps

// Sorted double-ended queue. Holds up to CAPACITY signed 32-bit values in
// ascending order in a row of cells, one value per cell. A beat is taken when
// start is high and busy is low. For insert, delete largest and delete
// smallest every cell compares or shifts in parallel at the accepting edge,
// the result is shown with done high in the next cycle and a new beat may be
// issued in every cycle. In a read, the first read stage folds each group of
// 32 cells into one registered word and the second folds those words into
// the registered item; busy is high in between.
// Every beat yields exactly one result beat, shown for a single cycle with
// done high; the receiver cannot hold it off, so it must sample it then.
// Results come in the order of the requests. After reset the count is zero;
// the cell contents are not cleared since only held entries are ever read.
// The count port carries the low seven bits of the held count.

module sorted_double_ended_queue_top #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sdeq_pkg::req_t req,
  output logic           done,
  output sdeq_pkg::rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NGRP = (CAPACITY + sdeq_pkg::GATHER_W - 1) / sdeq_pkg::GATHER_W;

  // control registers
  sdeq_pkg::ctl_state_t state, state_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic                 done_next;

  // payload registers
  sdeq_pkg::rsp_t       rsp_next;
  sdeq_pkg::status_t    rd_status, rd_status_next;
  logic signed [sdeq_pkg::VALUE_W-1:0] grp [NGRP];
  logic signed [sdeq_pkg::VALUE_W-1:0] grp_next [NGRP];

  // cell chain
  logic signed [sdeq_pkg::VALUE_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]                 less;
  sdeq_pkg::cell_ctl_t                 ctl;

  logic accept;
  logic full;
  logic empty;
  logic signed [sdeq_pkg::VALUE_W-1:0] gathered;

  assign busy   = (state == sdeq_pkg::CS_GATHER);
  assign accept = start && !busy;
  assign full   = (cnt == CW'(CAPACITY));
  assign empty  = (cnt == '0);

  // broadcast to every cell: insert only when room, front delete only when held
  always_comb begin
    ctl.value     = req.value;
    ctl.ins       = accept && (req.mode == sdeq_pkg::MODE_INSERT) && !full;
    ctl.del_front = accept && (req.mode == sdeq_pkg::MODE_DEL_SMALLEST) && !empty;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                               prev_less;
    logic signed [sdeq_pkg::VALUE_W-1:0] left_entry;
    logic signed [sdeq_pkg::VALUE_W-1:0] right_entry;

    // the first cell has nothing to its left, so it is the slot if not less
    if (i == 0) begin : g_first
      assign prev_less  = 1'b1;
      assign left_entry = entries[i];
    end else begin : g_mid
      assign prev_less  = less[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    sdeq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .valid       (cnt > CW'(i)),
      .prev_less   (prev_less),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .less        (less[i]),
      .entry       (entries[i])
    );
  end

  // first read stage: each group keeps the entry whose position matches
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < sdeq_pkg::GATHER_W; j++) begin
        if (g * sdeq_pkg::GATHER_W + j < CAPACITY) begin
          if (req.position == sdeq_pkg::POS_W'(g * sdeq_pkg::GATHER_W + j + 1)) begin
            grp_next[g] = grp_next[g] | entries[g * sdeq_pkg::GATHER_W + j];
          end
        end
      end
    end
  end

  // second read stage: at most one group holds a nonzero match
  always_comb begin
    gathered = '0;
    for (int g = 0; g < NGRP; g++) begin
      gathered = gathered | grp[g];
    end
  end

  // next state, count and result
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    done_next       = 1'b0;
    rd_status_next  = rd_status;
    rsp_next        = rsp;
    rsp_next.item   = '0;

    case (state)
      sdeq_pkg::CS_IDLE: begin
        if (accept) begin
          case (req.mode)
            sdeq_pkg::MODE_INSERT: begin
              if (full) begin
                rsp_next.status = sdeq_pkg::STAT_FULL;
              end else begin
                rsp_next.status = sdeq_pkg::STAT_OK;
                cnt_next        = cnt + CW'(1);
              end
              done_next = 1'b1;
            end
            sdeq_pkg::MODE_DEL_LARGEST, sdeq_pkg::MODE_DEL_SMALLEST: begin
              // the rear delete only drops the count, the front one also shifts
              if (empty) begin
                rsp_next.status = sdeq_pkg::STAT_EMPTY;
              end else begin
                rsp_next.status = sdeq_pkg::STAT_OK;
                cnt_next        = cnt - CW'(1);
              end
              done_next = 1'b1;
            end
            sdeq_pkg::MODE_READ: begin
              // empty list wins over a bad position
              if (empty) begin
                rd_status_next = sdeq_pkg::STAT_EMPTY;
              end else if (req.position == '0 ||
                           req.position > sdeq_pkg::POS_W'(cnt)) begin
                rd_status_next = sdeq_pkg::STAT_NOT_FOUND;
              end else begin
                rd_status_next = sdeq_pkg::STAT_OK;
              end
              state_next = sdeq_pkg::CS_GATHER;
            end
            default: begin
              done_next = 1'b0;
            end
          endcase
          rsp_next.count = sdeq_pkg::COUNT_W'(cnt_next);
        end
      end
      sdeq_pkg::CS_GATHER: begin
        rsp_next.status = rd_status;
        rsp_next.item   = (rd_status == sdeq_pkg::STAT_OK) ? gathered : '0;
        rsp_next.count  = sdeq_pkg::COUNT_W'(cnt);
        done_next       = 1'b1;
        state_next      = sdeq_pkg::CS_IDLE;
      end
      default: begin
        state_next = sdeq_pkg::CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdeq_pkg::CS_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp       <= rsp_next;
    rd_status <= rd_status_next;
    if (accept) begin
      for (int g = 0; g < NGRP; g++) begin
        grp[g] <= grp_next[g];
      end
    end
  end

endmodule

// ----- rtl/sdeq_checker.sv -----
// port-level checks of the sorted double-ended queue and their bind
`timescale 1ns / 1ps

module sdeq_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input sdeq_pkg::req_t req,
  input logic           done,
  input sdeq_pkg::rsp_t rsp
);

  // insert and deletes answer in the very next cycle
  a_fast_ops: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.mode != sdeq_pkg::MODE_READ) |=> (done && !busy))
    else $error("insert or delete beat not answered in the next cycle");

  // a read raises busy and then answers
  a_read_timing: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.mode == sdeq_pkg::MODE_READ) |=> (busy && !done) ##1 done)
    else $error("read beat did not follow the two-cycle sequence");

  // busy is always low in the cycle after it is high
  a_busy_short: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // item is only nonzero on a successful read
  a_item_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != sdeq_pkg::STAT_OK) |-> (rsp.item == '0))
    else $error("nonzero item on a failed beat");

endmodule

bind sorted_double_ended_queue_top sdeq_checker u_sdeq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);
